// ===== rtl/clt_pkg.sv =====
// ----------------------------------------------------------------------------
// clt_pkg: shared types and constants of the card locker table
// Outcome codes, item mode codes, the result record and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package clt_pkg;

  localparam int NUM_LOCKERS_DEF = 8;
  localparam int UID_BYTES_DEF   = 4;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CARD_PORT_W     = 32;
  localparam int LOCKER_INDEX_W  = 3;
  localparam int VACANT_COUNT_W  = 4;

  typedef enum logic [1:0] {
    OUT_OPENED      = 2'd0,
    OUT_RELEASED    = 2'd1,
    OUT_REGISTERED  = 2'd2,
    OUT_NONE_VACANT = 2'd3
  } clt_outcome_t;

  typedef enum logic {
    OP_OPEN    = 1'b0,
    OP_RELEASE = 1'b1
  } clt_op_t;

  typedef struct packed {
    clt_outcome_t                outcome;
    logic [LOCKER_INDEX_W-1:0]   locker_index;
    logic                        open_strobe;
    logic [VACANT_COUNT_W-1:0]   vacant_count;
    logic                        all_full;
  } clt_result_t;

  // stored/compared card bits: the UID bytes, capped at the port width
  function automatic int card_width(input int uid_bytes);
    int bits;
    bits = uid_bytes * 8;
    return (bits >= CARD_PORT_W) ? CARD_PORT_W : bits;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/card_locker_table_core.sv =====
// ----------------------------------------------------------------------------
// card_locker_table_core: card-operated locker bank table
// Matches scanned cards against the locker table, opens, releases or
// registers lockers and reports the vacant count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_operation and in_card_number with start high; the
//   item is taken on a clock edge where busy is low. A two-entry queue sits
//   in front of the table engine, so busy only rises when two items wait.
//   Result channel: out_valid is high for exactly one cycle per item with the
//   outcome, locker index, open strobe, vacant count and full flag. The
//   receiver cannot stall; every result must be taken in its cycle.
//   Timing: the engine walks the table one locker per cycle through the card
//   RAM read port. It finishes one item (early when the card matches) before
//   it pops the next from the queue. Results come out in acceptance order.
//   Reset: synchronous, active low. Afterwards every locker is vacant and the
//   vacant count equals NUM_LOCKERS; the queue is empty. The card RAM is not
//   cleared: an entry is only matched while its occupied flag is set.
// ----------------------------------------------------------------------------
`default_nettype none

module card_locker_table_core
  import clt_pkg::*;
#(
  parameter int NUM_LOCKERS = NUM_LOCKERS_DEF,
  parameter int UID_BYTES   = UID_BYTES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      in_operation,
  input  wire logic [CARD_PORT_W-1:0]    in_card_number,
  output logic                           out_valid,
  output logic      [1:0]                out_outcome,
  output logic      [LOCKER_INDEX_W-1:0] out_locker_index,
  output logic                           out_open_strobe,
  output logic      [VACANT_COUNT_W-1:0] out_vacant_count,
  output logic                           out_all_full
);

  localparam int CARD_W = card_width(UID_BYTES);

  logic              pop;
  logic              head_vld;
  clt_op_t           head_op;
  logic [CARD_W-1:0] head_card;
  clt_result_t       res;

  clt_queue #(
    .CARD_W (CARD_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_card_number (in_card_number),
    .pop            (pop),
    .head_vld       (head_vld),
    .head_op        (head_op),
    .head_card      (head_card)
  );

  clt_engine #(
    .NUM_LOCKERS (NUM_LOCKERS),
    .CARD_W      (CARD_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_vld  (head_vld),
    .head_op   (head_op),
    .head_card (head_card),
    .pop       (pop),
    .res_vld   (out_valid),
    .res       (res)
  );

  assign out_outcome      = res.outcome;
  assign out_locker_index = res.locker_index;
  assign out_open_strobe  = res.open_strobe;
  assign out_vacant_count = res.vacant_count;
  assign out_all_full     = res.all_full;

endmodule

`default_nettype wire

// ===== rtl/clt_ram.sv =====
// ----------------------------------------------------------------------------
// clt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/clt_queue.sv =====
// ----------------------------------------------------------------------------
// clt_queue: front end of the card locker table
// Accepts scan items, decodes the mode, trims the card and queues the item
// for the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_queue
  import clt_pkg::*;
#(
  parameter int CARD_W = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   in_operation,
  input  wire logic [CARD_PORT_W-1:0] in_card_number,
  input  wire logic                   pop,
  output logic                        head_vld,
  output clt_op_t                     head_op,
  output logic      [CARD_W-1:0]      head_card
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
  localparam logic [NW-1:0] FULL_N   = NW'(QUEUE_DEPTH);

  clt_op_t           op_q   [QUEUE_DEPTH];
  logic [CARD_W-1:0] card_q [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]     cnt_r, cnt_nxt;
  logic              push, take;

  assign busy      = (cnt_r == FULL_N);
  assign head_vld  = (cnt_r != '0);
  assign head_op   = op_q[rd_ptr_r];
  assign head_card = card_q[rd_ptr_r];

  assign push = start && !busy;
  assign take = pop && head_vld;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (take) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !take) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (take && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload slots, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      op_q[wr_ptr_r]   <= clt_op_t'(in_operation);
      card_q[wr_ptr_r] <= in_card_number[CARD_W-1:0];
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_N)
    else $error("queue count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy && !take |=> cnt_r == FULL_N)
    else $error("queue lost an entry while full");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == FULL_N) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers out of step with count");

endmodule

`default_nettype wire

// ===== rtl/clt_engine.sv =====
// ----------------------------------------------------------------------------
// clt_engine: back end of the card locker table
// Walks the locker table one entry per cycle, looks for the card among the
// occupied lockers, tracks the lowest vacant one and applies the update.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_engine
  import clt_pkg::*;
#(
  parameter int NUM_LOCKERS = NUM_LOCKERS_DEF,
  parameter int CARD_W      = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              head_vld,
  input  wire clt_op_t           head_op,
  input  wire logic [CARD_W-1:0] head_card,
  output logic                   pop,
  output logic                   res_vld,
  output clt_result_t            res
);

  localparam int IW = (NUM_LOCKERS > 1) ? $clog2(NUM_LOCKERS) : 1;
  localparam int CW = $clog2(NUM_LOCKERS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_LOCKERS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(NUM_LOCKERS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t                 state_r, state_nxt;
  clt_op_t                op_r, op_nxt;
  logic [CARD_W-1:0]      card_r, card_nxt;
  logic                   issue_r, issue_nxt;
  logic [IW-1:0]          scan_idx_r, scan_idx_nxt;
  logic                   chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]          chk_idx_r, chk_idx_nxt;
  logic                   vac_fnd_r, vac_fnd_nxt;
  logic [IW-1:0]          vac_idx_r, vac_idx_nxt;
  logic [NUM_LOCKERS-1:0] occ_r, occ_nxt;
  logic [CW-1:0]          vac_total_r, vac_total_nxt;
  logic                   res_vld_r, res_vld_nxt;
  clt_result_t            res_r, res_nxt;

  logic [CARD_W-1:0]      rd_data;
  logic                   we;
  logic                   cur_occ, hit, cur_free, last, have_vac, finish;
  logic [IW-1:0]          new_idx, res_idx;

  clt_ram #(
    .WIDTH (CARD_W),
    .DEPTH (NUM_LOCKERS)
  ) u_cards (
    .clk   (clk),
    .we    (we),
    .waddr (new_idx),
    .wdata (card_r),
    .raddr (scan_idx_r),
    .rdata (rd_data)
  );

  // compare stage sees the entry read in the previous cycle
  assign cur_occ  = occ_r[chk_idx_r];
  assign hit      = chk_vld_r && cur_occ && (rd_data == card_r);
  assign cur_free = chk_vld_r && !cur_occ;
  assign last     = chk_vld_r && (chk_idx_r == LAST_IDX);
  assign have_vac = vac_fnd_r || cur_free;
  assign new_idx  = vac_fnd_r ? vac_idx_r : chk_idx_r;
  assign finish   = (state_r == ST_SCAN) && (hit || last);

  assign pop = (state_r == ST_IDLE) && head_vld;
  assign we  = finish && !hit && have_vac;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    card_nxt      = card_r;
    issue_nxt     = issue_r;
    scan_idx_nxt  = scan_idx_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    vac_fnd_nxt   = vac_fnd_r;
    vac_idx_nxt   = vac_idx_r;
    occ_nxt       = occ_r;
    vac_total_nxt = vac_total_r;
    res_vld_nxt   = 1'b0;
    res_idx       = '0;
    res_nxt       = res_r;
    case (state_r)
      ST_IDLE: begin
        if (head_vld) begin
          op_nxt       = head_op;
          card_nxt     = head_card;
          issue_nxt    = 1'b1;
          scan_idx_nxt = '0;
          chk_vld_nxt  = 1'b0;
          vac_fnd_nxt  = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        chk_vld_nxt = issue_r;
        if (issue_r) begin
          chk_idx_nxt = scan_idx_r;
          if (scan_idx_r == LAST_IDX) begin
            issue_nxt = 1'b0;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end
        if (cur_free && !vac_fnd_r) begin
          vac_fnd_nxt = 1'b1;
          vac_idx_nxt = chk_idx_r;
        end
        if (hit || last) begin
          state_nxt   = ST_IDLE;
          issue_nxt   = 1'b0;
          chk_vld_nxt = 1'b0;
          res_vld_nxt = 1'b1;
          if (hit) begin
            res_idx = chk_idx_r;
            if (op_r == OP_RELEASE) begin
              occ_nxt[chk_idx_r] = 1'b0;
              if (vac_total_r != FULL_CNT) begin
                vac_total_nxt = vac_total_r + 1'b1;
              end
              res_nxt.outcome = OUT_RELEASED;
            end else begin
              res_nxt.outcome = OUT_OPENED;
            end
            res_nxt.open_strobe = 1'b1;
          end else if (have_vac) begin
            // unknown card: claim the lowest vacant locker
            res_idx          = new_idx;
            occ_nxt[new_idx] = 1'b1;
            if (vac_total_r != '0) begin
              vac_total_nxt = vac_total_r - 1'b1;
            end
            res_nxt.outcome     = OUT_REGISTERED;
            res_nxt.open_strobe = 1'b1;
          end else begin
            res_nxt.outcome     = OUT_NONE_VACANT;
            res_nxt.open_strobe = 1'b0;
          end
          res_nxt.locker_index = LOCKER_INDEX_W'(res_idx);
          res_nxt.vacant_count = VACANT_COUNT_W'(vac_total_nxt);
          res_nxt.all_full     = (vac_total_nxt == '0);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_r     <= 1'b0;
      chk_vld_r   <= 1'b0;
      vac_fnd_r   <= 1'b0;
      occ_r       <= '0;
      vac_total_r <= FULL_CNT;
      res_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      chk_vld_r   <= chk_vld_nxt;
      vac_fnd_r   <= vac_fnd_nxt;
      occ_r       <= occ_nxt;
      vac_total_r <= vac_total_nxt;
      res_vld_r   <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    card_r     <= card_nxt;
    scan_idx_r <= scan_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    vac_idx_r  <= vac_idx_nxt;
    res_r      <= res_nxt;
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(occ_r) + int'(vac_total_r) == NUM_LOCKERS)
    else $error("vacant count disagrees with occupied flags");

  a_res_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r |-> $past(state_r == ST_SCAN))
    else $error("result without a table scan");

  a_strobe_code: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r |-> (res_r.open_strobe == (res_r.outcome != OUT_NONE_VACANT)))
    else $error("open strobe disagrees with outcome");

  a_fail_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r && res_r.outcome == OUT_NONE_VACANT |-> res_r.all_full)
    else $error("scan failed while a locker was vacant");

  a_pop_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r == ST_SCAN && issue_r)
    else $error("popped item did not start a scan");

endmodule

`default_nettype wire

// ===== sim/tb_card_locker_table_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_card_locker_table_core: self-checking bench of the card locker table
// Drives card scans through the start/busy port in bursts, keeps its own
// copy of the locker table to predict every result and compares each
// out_valid item field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_card_locker_table_core;
  import clt_pkg::*;

  localparam int LOCKERS        = NUM_LOCKERS_DEF;
  localparam int UID_BYTES      = UID_BYTES_DEF;
  localparam int CARD_BITS      = (UID_BYTES * 8 >= CARD_PORT_W) ? CARD_PORT_W
                                                                 : UID_BYTES * 8;
  localparam logic [CARD_PORT_W-1:0] CARD_MASK =
    {CARD_PORT_W{1'b1}} >> (CARD_PORT_W - CARD_BITS);
  localparam int RANDOM_SCANS   = 400;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int DRAIN_CYCLES   = LOCKERS + 8;
  localparam int POOL_SIZE      = 12;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_operation;
  logic [CARD_PORT_W-1:0]    in_card_number;
  logic                      out_valid;
  logic [1:0]                out_outcome;
  logic [LOCKER_INDEX_W-1:0] out_locker_index;
  logic                      out_open_strobe;
  logic [VACANT_COUNT_W-1:0] out_vacant_count;
  logic                      out_all_full;

  // Locker table predictor plus the queue of results still owed by the block
  class locker_bank;
    bit                     occupied[LOCKERS];
    logic [CARD_PORT_W-1:0] cards[LOCKERS];
    int                     vacant;
    clt_result_t            awaited[$];
    int                     mismatches;

    function new();
      foreach (occupied[i]) occupied[i] = 1'b0;
      vacant     = LOCKERS;
      mismatches = 0;
    endfunction

    function void take_scan(clt_op_t op, logic [CARD_PORT_W-1:0] card);
      logic [CARD_PORT_W-1:0] key;
      int                     hit;
      int                     slot;
      clt_result_t            res;
      key              = card & CARD_MASK;
      hit              = -1;
      slot             = -1;
      res.outcome      = OUT_NONE_VACANT;
      res.locker_index = '0;
      res.open_strobe  = 1'b0;
      for (int i = 0; i < LOCKERS; i++)
        if (hit < 0 && occupied[i] && cards[i] == key) hit = i;
      if (hit >= 0) begin
        res.locker_index = hit[LOCKER_INDEX_W-1:0];
        res.open_strobe  = 1'b1;
        if (op == OP_RELEASE) begin
          occupied[hit] = 1'b0;
          if (vacant < LOCKERS) vacant++;
          res.outcome = OUT_RELEASED;
        end else begin
          res.outcome = OUT_OPENED;
        end
      end else begin
        // release of an unknown card registers it like a plain open
        for (int i = 0; i < LOCKERS; i++)
          if (slot < 0 && !occupied[i]) slot = i;
        if (slot >= 0) begin
          occupied[slot]   = 1'b1;
          cards[slot]      = key;
          if (vacant > 0) vacant--;
          res.outcome      = OUT_REGISTERED;
          res.locker_index = slot[LOCKER_INDEX_W-1:0];
          res.open_strobe  = 1'b1;
        end
      end
      res.vacant_count = vacant[VACANT_COUNT_W-1:0];
      res.all_full     = (vacant == 0);
      awaited.push_back(res);
    endfunction

    function void check_result(clt_result_t got);
      clt_result_t exp;
      if (awaited.size() == 0) begin
        $error("unexpected result: outcome %0d locker %0d", got.outcome, got.locker_index);
        mismatches++;
        return;
      end
      exp = awaited.pop_front();
      if (got.outcome !== exp.outcome) begin
        $error("outcome: expected %0d, got %0d", exp.outcome, got.outcome);
        mismatches++;
      end
      if (got.locker_index !== exp.locker_index) begin
        $error("locker_index: expected %0d, got %0d", exp.locker_index, got.locker_index);
        mismatches++;
      end
      if (got.open_strobe !== exp.open_strobe) begin
        $error("open_strobe: expected %0d, got %0d", exp.open_strobe, got.open_strobe);
        mismatches++;
      end
      if (got.vacant_count !== exp.vacant_count) begin
        $error("vacant_count: expected %0d, got %0d", exp.vacant_count, got.vacant_count);
        mismatches++;
      end
      if (got.all_full !== exp.all_full) begin
        $error("all_full: expected %0d, got %0d", exp.all_full, got.all_full);
        mismatches++;
      end
    endfunction
  endclass

  locker_bank bank = new();

  logic [CARD_PORT_W-1:0] card_pool[POOL_SIZE];

  card_locker_table_core #(
    .NUM_LOCKERS(LOCKERS),
    .UID_BYTES  (UID_BYTES)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_card_number  (in_card_number),
    .out_valid       (out_valid),
    .out_outcome     (out_outcome),
    .out_locker_index(out_locker_index),
    .out_open_strobe (out_open_strobe),
    .out_vacant_count(out_vacant_count),
    .out_all_full    (out_all_full)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Monitor: scans and results are taken at the rising edge
  always @(posedge clk) begin
    clt_result_t got;
    if (rst_n && start && !busy)
      bank.take_scan(clt_op_t'(in_operation), in_card_number);
    if (rst_n && out_valid) begin
      got.outcome      = clt_outcome_t'(out_outcome);
      got.locker_index = out_locker_index;
      got.open_strobe  = out_open_strobe;
      got.vacant_count = out_vacant_count;
      got.all_full     = out_all_full;
      bank.check_result(got);
    end
  end

  // Watchdog: too many cycles without any accepted item or result ends the run
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) quiet = 0;
      else quiet++;
    end
    $display("tb_card_locker_table_core: errors");
    $finish;
  end

  task automatic send_scan(clt_op_t op, logic [CARD_PORT_W-1:0] card);
    @(negedge clk);
    start          = 1'b1;
    in_operation   = op;
    in_card_number = card;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(int cycles);
    @(negedge clk);
    start          = 1'b0;
    in_operation   = 1'($urandom);
    in_card_number = $urandom;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic send_random(int seq);
    int      release_pct;
    clt_op_t op;
    logic [CARD_PORT_W-1:0] card;
    // phases lean toward filling or draining the table in turn
    case (seq / 100)
      0:       release_pct = 30;
      1:       release_pct = 15;
      2:       release_pct = 75;
      default: release_pct = 50;
    endcase
    op = ($urandom_range(99) < release_pct) ? OP_RELEASE : OP_OPEN;
    if ($urandom_range(99) < 85) card = card_pool[$urandom_range(POOL_SIZE - 1)];
    else card = $urandom;
    send_scan(op, card);
  endtask

  initial begin
    int sent;
    int burst;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_operation   = 1'b0;
    in_card_number = '0;
    foreach (card_pool[i]) card_pool[i] = $urandom;
    // near misses: a single flipped bit must not match
    card_pool[10] = card_pool[3] ^ (32'd1 << $urandom_range(31));
    card_pool[11] = card_pool[5] ^ 32'h8000_0000;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, fill to full, refusals, opens, releases
    send_scan(OP_OPEN,    32'h0000_0000);
    send_scan(OP_OPEN,    32'hFFFF_FFFF);
    send_scan(OP_OPEN,    32'h0000_0000);
    send_scan(OP_RELEASE, 32'hFFFF_FFFF);
    send_scan(OP_RELEASE, 32'hA5A5_5A5A);
    send_scan(OP_OPEN,    32'h8000_0000);
    send_scan(OP_OPEN,    32'h0000_0001);
    send_scan(OP_OPEN,    32'h1234_5678);
    hold_off(5);
    send_scan(OP_OPEN,    32'hFFFF_FFFE);
    send_scan(OP_OPEN,    32'h7FFF_FFFF);
    send_scan(OP_OPEN,    32'hDEAD_BEEF);
    send_scan(OP_OPEN,    32'hCAFE_F00D);
    send_scan(OP_RELEASE, 32'h0BAD_0BAD);
    send_scan(OP_OPEN,    32'hDEAD_BEEF);
    send_scan(OP_RELEASE, 32'h1234_5678);
    send_scan(OP_OPEN,    32'h1234_5679);
    send_scan(OP_RELEASE, 32'h0000_0000);
    send_scan(OP_RELEASE, 32'hA5A5_5A5A);
    send_scan(OP_RELEASE, 32'h8000_0000);
    send_scan(OP_RELEASE, 32'h0000_0001);
    send_scan(OP_RELEASE, 32'h1234_5679);
    send_scan(OP_RELEASE, 32'hFFFF_FFFE);
    send_scan(OP_RELEASE, 32'h7FFF_FFFF);
    send_scan(OP_RELEASE, 32'hDEAD_BEEF);

    sent = 0;
    while (sent < RANDOM_SCANS) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && sent < RANDOM_SCANS; k++) begin
        send_random(sent);
        sent++;
      end
      if ($urandom_range(3) != 0) hold_off($urandom_range(1, 15));
    end

    @(negedge clk);
    start = 1'b0;
    while (bank.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (bank.awaited.size() != 0) begin
      $error("%0d results never arrived", bank.awaited.size());
      bank.mismatches++;
    end
    if (bank.mismatches == 0)
      $display("tb_card_locker_table_core: clean");
    else
      $display("tb_card_locker_table_core: errors");
    $finish;
  end

endmodule
